@@ hw/rtl/db_to_linear_volume_gain_assert.svh @@
// ----------------------------------------------------------------------------
// db_to_linear_volume_gain assertion macros
// shared concurrent assertion forms used by the volume gain block
// ----------------------------------------------------------------------------
`ifndef DB_TO_LINEAR_VOLUME_GAIN_ASSERT_SVH
`define DB_TO_LINEAR_VOLUME_GAIN_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DLVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DLVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dlvg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlvg_pkg
// widths, constants and register indexes of the volume to gain converter
// ----------------------------------------------------------------------------
package dlvg_pkg;

  // field widths
  localparam int VOL_W     = 16;
  localparam int VOL_EXT_W = 18;  // room for volume minus half a dB
  localparam int GAIN_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  // default accumulator width (unsigned), gain uses GAIN_BITS-1 bits
  localparam int GAIN_BITS_DEF = 32;

  // step sizes in 1/256 dB
  localparam logic signed [VOL_EXT_W-1:0] HALF_DB     = 18'sd128;
  localparam logic signed [VOL_EXT_W-1:0] SIX_DB      = 18'sd1536;
  localparam logic signed [VOL_EXT_W-1:0] NEG_HALF_DB = -18'sd128;
  localparam logic signed [VOL_EXT_W-1:0] NEG_SIX_DB  = -18'sd1536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNITY_GAIN = 2'd2;

  // register reset values
  localparam logic signed [VOL_W-1:0] MIN_VOLUME_RST = -16'sd32640;
  localparam logic signed [VOL_W-1:0] MAX_VOLUME_RST = 16'sd0;
  localparam logic [GAIN_W-1:0]       UNITY_GAIN_RST = 31'd16777216;

endpackage

@@ hw/rtl/db_to_linear_volume_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_to_linear_volume_gain
// converts a volume in 1/256 dB into a linear gain multiplier
// ----------------------------------------------------------------------------
// A volume transfer outside [min_volume, max_volume] returns gain 0 with muted
// set, going straight from ST_IDLE to ST_DONE. Otherwise the volume is lowered
// by half a dB and a small sequencer drives one shared shift/subtract unit:
// ST_HALVE does one 6 dB halving of the gain per step (up to 21), then ST_FRAC
// does one half-dB g -= g>>4 step at a time (up to 11), and ST_DONE loads the
// output register. The two counts never peak together (at most 31 steps in
// all). in_stall stays high from the accepting edge until the result is in the
// output register; the output register lets the next volume be taken while a
// result waits on out_stall.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
`include "db_to_linear_volume_gain_assert.svh"

module db_to_linear_volume_gain #(
  parameter int GAIN_BITS = dlvg_pkg::GAIN_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dlvg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlvg_pkg::CFG_DATA_W-1:0]       cfg_data,
  // volume input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [dlvg_pkg::VOL_W-1:0]     in_volume_db,
  // gain result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dlvg_pkg::GAIN_W-1:0]           out_gain,
  output logic                                  out_muted
);

  // working gain width: low GAIN_BITS-1 bits of unity_gain
  localparam int GW = GAIN_BITS - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HALVE,
    ST_FRAC,
    ST_DONE
  } state_t;

  // configuration registers
  logic signed [dlvg_pkg::VOL_W-1:0]  min_volume_r, min_volume_nxt;
  logic signed [dlvg_pkg::VOL_W-1:0]  max_volume_r, max_volume_nxt;
  logic [dlvg_pkg::GAIN_W-1:0]        unity_gain_r, unity_gain_nxt;

  // sequencer and working registers
  state_t                                 state_r, state_nxt;
  logic signed [dlvg_pkg::VOL_EXT_W-1:0]  vol_r, vol_nxt;
  logic [GW-1:0]                          g_r, g_nxt;
  logic                                   muted_r, muted_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic [dlvg_pkg::GAIN_W-1:0]        out_gain_r, out_gain_nxt;
  logic                               out_muted_r, out_muted_nxt;

  logic in_xfer;
  logic out_xfer;
  logic cfg_xfer;
  logic in_range;
  logic signed [dlvg_pkg::VOL_EXT_W-1:0] vol_in_ext;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;

  assign out_valid = out_valid_r;
  assign out_gain  = out_gain_r;
  assign out_muted = out_muted_r;

  assign vol_in_ext = dlvg_pkg::VOL_EXT_W'(in_volume_db);
  assign in_range   = !(in_volume_db < min_volume_r) && !(in_volume_db > max_volume_r);

  always_comb begin
    min_volume_nxt = min_volume_r;
    max_volume_nxt = max_volume_r;
    unity_gain_nxt = unity_gain_r;
    state_nxt      = state_r;
    vol_nxt        = vol_r;
    g_nxt          = g_r;
    muted_nxt      = muted_r;
    out_valid_nxt  = out_valid_r && !out_xfer;
    out_gain_nxt   = out_gain_r;
    out_muted_nxt  = out_muted_r;

    // register writes, out-of-list indexes are dropped
    if (cfg_xfer) begin
      unique case (cfg_index)
        dlvg_pkg::REG_MIN_VOLUME: min_volume_nxt = cfg_data[dlvg_pkg::VOL_W-1:0];
        dlvg_pkg::REG_MAX_VOLUME: max_volume_nxt = cfg_data[dlvg_pkg::VOL_W-1:0];
        dlvg_pkg::REG_UNITY_GAIN: unity_gain_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_range) begin
            vol_nxt   = vol_in_ext - dlvg_pkg::HALF_DB;
            g_nxt     = GW'(unity_gain_r);
            muted_nxt = 1'b0;
            state_nxt = ST_HALVE;
          end else begin
            g_nxt     = '0;
            muted_nxt = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      // one halving per full 6 dB below -6 dB
      ST_HALVE: begin
        if (vol_r < dlvg_pkg::NEG_SIX_DB) begin
          g_nxt   = g_r >> 1;
          vol_nxt = vol_r + dlvg_pkg::SIX_DB;
        end else begin
          state_nxt = ST_FRAC;
        end
      end
      // one sixteenth off per half dB below -0.5 dB
      ST_FRAC: begin
        if (vol_r < dlvg_pkg::NEG_HALF_DB) begin
          g_nxt   = g_r - (g_r >> 4);
          vol_nxt = vol_r + dlvg_pkg::HALF_DB;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      // hand the result over once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          out_gain_nxt  = dlvg_pkg::GAIN_W'(g_r);
          out_muted_nxt = muted_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      min_volume_r <= dlvg_pkg::MIN_VOLUME_RST;
      max_volume_r <= dlvg_pkg::MAX_VOLUME_RST;
      unity_gain_r <= dlvg_pkg::UNITY_GAIN_RST;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      min_volume_r <= min_volume_nxt;
      max_volume_r <= max_volume_nxt;
      unity_gain_r <= unity_gain_nxt;
    end
    // payload, no reset needed
    vol_r       <= vol_nxt;
    g_r         <= g_nxt;
    muted_r     <= muted_nxt;
    out_gain_r  <= out_gain_nxt;
    out_muted_r <= out_muted_nxt;
  end

  // assertions
  `DLVG_ASSERT_IMP(a_muted_zero, clk, rst_n, out_valid_r && out_muted_r,
    out_gain_r == '0, "muted result with nonzero gain")
  `DLVG_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_xfer,
    state_r != ST_IDLE, "sequencer idle after volume transfer")
  `DLVG_ASSERT_IMP(a_frac_range, clk, rst_n, state_r == ST_FRAC,
    !(vol_r < dlvg_pkg::NEG_SIX_DB), "sixteenth step entered before halving finished")
  `DLVG_ASSERT_NXT(a_gain_nonincr, clk, rst_n, state_r == ST_HALVE || state_r == ST_FRAC,
    g_r <= $past(g_r), "gain grew during iteration")
  `DLVG_ASSERT_NXT(a_done_loads, clk, rst_n, state_r == ST_DONE && !out_valid_r,
    out_valid_r && state_r == ST_IDLE, "result not loaded into free output register")

endmodule
